// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define FCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define FCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fcr_pkg.sv
// Package with constants, types and the CRC step of the frame reassembler.
`default_nettype none

package fcr_pkg;

  localparam int FRAME_PAYLOAD_BYTES = 8;
  localparam int BLOB_BYTES          = 130;
  localparam int FRAMES_PER_BLOB     = (BLOB_BYTES + FRAME_PAYLOAD_BYTES - 1) /
                                       FRAME_PAYLOAD_BYTES;
  localparam int HDR_BYTES           = 12;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam int TAG_W     = 16;
  localparam int IDX_W     = 8;
  localparam int WORD_W    = 32;
  localparam int PAYLOAD_W = 64;
  localparam int TOTAL_W   = $clog2(FRAMES_PER_BLOB + 1);
  // The accepted-frame count can run one past the largest index.
  localparam int NEXT_W    = IDX_W + 1;
  localparam int POS_W     = $clog2((1 << IDX_W) * FRAME_PAYLOAD_BYTES);
  localparam int CFG_IDX_W = 2;

  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_TAG,
    REG_MAGIC,
    REG_VERSION
  } cfg_reg_t;

  // Reassembly context kept in the state word.
  typedef struct packed {
    logic [TOTAL_W-1:0] exp_total;
    logic [NEXT_W-1:0]  next_frame;
    logic [WORD_W-1:0]  crc;
    logic [WORD_W-1:0]  magic;
    logic [WORD_W-1:0]  version;
    logic [WORD_W-1:0]  stored_crc;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    exp_total:  '0,
    next_frame: '0,
    crc:        CRC_INIT,
    magic:      '0,
    version:    '0,
    stored_crc: '0
  };

  // One reflected CRC-32 byte update.
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                 input logic [7:0] data);
    logic [WORD_W-1:0] c;
    c = crc_in ^ {{(WORD_W-8){1'b0}}, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/config_frame_reassembler_crc32_core.sv
// Configuration frame reassembler with CRC-32 blob check, top level.
// The execute stage takes the transaction and the result register offers the verdict.
// Throughput: one frame per cycle while the result channel does not stall, set by the
// read-modify-write of the single context word, with the just-written context
// forwarded, and the eight-byte CRC update.
// Reset: synchronous, active low; clears the pipeline and configuration and writes the
// reset context into the context word during the reset cycle.
`default_nettype none
`include "assert_macros.svh"

module config_frame_reassembler_crc32_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [fcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fcr_pkg::WORD_W-1:0]       cfg_wdata,
  // Frame input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_kind,
  input  wire logic [fcr_pkg::TAG_W-1:0]        in_frame_tag,
  input  wire logic [fcr_pkg::IDX_W-1:0]        in_frame_index,
  input  wire logic [fcr_pkg::IDX_W-1:0]        in_frame_total,
  input  wire logic [fcr_pkg::PAYLOAD_W-1:0]    in_payload_bytes,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_accepted,
  output logic                                  out_complete,
  output logic                                  out_blob_valid
);
  import fcr_pkg::*;

  // Configuration registers
  logic [TAG_W-1:0]  tag_value_r;
  logic [WORD_W-1:0] exp_magic_r;
  logic [WORD_W-1:0] exp_version_r;

  // Execute stage
  logic                 b_valid_r;
  logic                 b_kind_r;
  logic [TAG_W-1:0]     b_tag_r;
  logic [IDX_W-1:0]     b_idx_r;
  logic [IDX_W-1:0]     b_total_r;
  logic [PAYLOAD_W-1:0] b_payload_r;

  // Context word, its registered read data and the forwarding path
  ctx_t ctx_mem [1];
  ctx_t rd_ctx_r;
  ctx_t fwd_ctx_r;
  logic fwd_r;

  ctx_t ctx_cur;
  ctx_t ctx_nxt;

  logic out_valid_r;
  logic out_accepted_r;
  logic out_complete_r;
  logic out_blob_valid_r;

  logic in_fire;
  logic b_fire;
  logic res_accepted;
  logic res_complete;
  logic res_blob_valid;

  assign b_fire   = b_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !b_valid_r || b_fire;
  assign in_fire  = in_valid && in_ready;

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_complete   = out_complete_r;
  assign out_blob_valid = out_blob_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_value_r   <= '0;
      exp_magic_r   <= '0;
      exp_version_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_TAG: tag_value_r   <= cfg_wdata[TAG_W-1:0];
        REG_MAGIC:     exp_magic_r   <= cfg_wdata;
        REG_VERSION:   exp_version_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The context word is written by the item leaving the execute stage. A read issued
  // in that same cycle sees the old word, so the written value is forwarded instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_mem[0] <= CTX_RESET;
    end else if (b_fire) begin
      ctx_mem[0] <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_ctx_r    <= ctx_mem[0];
      fwd_ctx_r   <= ctx_nxt;
      b_kind_r    <= in_kind;
      b_tag_r     <= in_frame_tag;
      b_idx_r     <= in_frame_index;
      b_total_r   <= in_frame_total;
      b_payload_r <= in_payload_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r     <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        fwd_r <= b_fire;
      end
      if (in_fire) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  assign ctx_cur = fwd_r ? fwd_ctx_r : rd_ctx_r;

  always_comb begin
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    ctx_nxt        = ctx_cur;
    res_accepted   = 1'b0;
    res_complete   = 1'b0;
    res_blob_valid = 1'b0;
    pos            = '0;
    data           = '0;
    if (b_kind_r == KIND_RESTART) begin
      ctx_nxt.exp_total  = '0;
      ctx_nxt.next_frame = '0;
      ctx_nxt.crc        = CRC_INIT;
    end else if (b_tag_r == tag_value_r && b_total_r != '0 &&
                 b_total_r <= IDX_W'(FRAMES_PER_BLOB)) begin
      // Index zero restarts the blob before the order checks.
      if (b_idx_r == '0) begin
        ctx_nxt.exp_total  = TOTAL_W'(b_total_r);
        ctx_nxt.next_frame = '0;
        ctx_nxt.crc        = CRC_INIT;
      end
      if (IDX_W'(ctx_nxt.exp_total) == b_total_r &&
          NEXT_W'(b_idx_r) == ctx_nxt.next_frame) begin
        for (int i = 0; i < FRAME_PAYLOAD_BYTES; i++) begin
          pos  = POS_W'(b_idx_r) * POS_W'(FRAME_PAYLOAD_BYTES) + POS_W'(i);
          data = b_payload_r[8*i +: 8];
          if (pos < POS_W'(BLOB_BYTES)) begin
            if (pos < POS_W'(4)) begin
              ctx_nxt.magic[{pos[1:0], 3'b000} +: 8] = data;
            end else if (pos < POS_W'(8)) begin
              ctx_nxt.version[{pos[1:0], 3'b000} +: 8] = data;
            end else if (pos < POS_W'(HDR_BYTES)) begin
              ctx_nxt.stored_crc[{pos[1:0], 3'b000} +: 8] = data;
            end else begin
              ctx_nxt.crc = crc_byte(ctx_nxt.crc, data);
            end
          end
        end
        ctx_nxt.next_frame = ctx_nxt.next_frame + NEXT_W'(1);
        res_accepted   = 1'b1;
        res_complete   = ctx_nxt.next_frame >= NEXT_W'(ctx_nxt.exp_total);
        // The blob is valid once enough frames cover all of its bytes and magic, version and CRC match.
        res_blob_valid = res_complete &&
                         ctx_nxt.next_frame >= NEXT_W'(FRAMES_PER_BLOB) &&
                         ctx_nxt.magic == exp_magic_r &&
                         ctx_nxt.version == exp_version_r &&
                         ~ctx_nxt.crc == ctx_nxt.stored_crc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_accepted_r   <= res_accepted;
      out_complete_r   <= res_complete;
      out_blob_valid_r <= res_blob_valid;
    end
  end

  `FCR_ASSERT_IMP(a_complete_needs_accept, out_valid && out_complete, out_accepted,
                  "complete reported for a frame that was not accepted")
  `FCR_ASSERT_IMP(a_blob_needs_complete, out_valid && out_blob_valid, out_complete,
                  "blob reported valid without completion")
  `FCR_ASSERT_NXT(a_fwd_on_overlap, in_fire && b_fire, fwd_r,
                  "context written in the read cycle was not forwarded")
  `FCR_ASSERT_NXT(a_exec_holds, b_valid_r && !b_fire, b_valid_r,
                  "execute stage dropped a stalled transaction")

endmodule

`default_nettype wire
